FILE: rtl/i2c_register_transfer_master_defines.svh
// Assertion macros used by the rtl checker file
`ifndef I2C_REGISTER_TRANSFER_MASTER_DEFINES_SVH
`define I2C_REGISTER_TRANSFER_MASTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high
`define RTM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2c register transfer master: check failed");

// Next-cycle implication, disabled while reset is high
`define RTM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2c register transfer master: check failed");

`endif

FILE: rtl/i2c_rtm_pkg.sv
package i2c_rtm_pkg;

   // Command codes
   localparam logic [1:0] CMD_WRITE  = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_STATUS = 2'd2;

   // Bus status codes
   localparam logic [3:0] ST_START     = 4'd0;
   localparam logic [3:0] ST_RSTART    = 4'd1;
   localparam logic [3:0] ST_SLAW_ACK  = 4'd2;
   localparam logic [3:0] ST_SLAW_NACK = 4'd3;
   localparam logic [3:0] ST_TX_ACK    = 4'd4;
   localparam logic [3:0] ST_TX_NACK   = 4'd5;
   localparam logic [3:0] ST_ARB_LOST  = 4'd6;
   localparam logic [3:0] ST_SLAR_ACK  = 4'd7;
   localparam logic [3:0] ST_SLAR_NACK = 4'd8;
   localparam logic [3:0] ST_RX_ACK    = 4'd9;
   localparam logic [3:0] ST_RX_NACK   = 4'd10;

   // Bus action codes
   localparam logic [2:0] ACT_NONE    = 3'd0;
   localparam logic [2:0] ACT_START   = 3'd1;
   localparam logic [2:0] ACT_SEND    = 3'd2;
   localparam logic [2:0] ACT_RX_ACK  = 3'd3;
   localparam logic [2:0] ACT_RX_NACK = 3'd4;
   localparam logic [2:0] ACT_STOP    = 3'd5;

   // Outcome codes
   localparam logic [1:0] OC_OK        = 2'd0;
   localparam logic [1:0] OC_RETRIES   = 2'd1;
   localparam logic [1:0] OC_START_ERR = 2'd2;
   localparam logic [1:0] OC_BUS_ERR   = 2'd3;

   // Register map
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RETRY_LIMIT    = 8'd1;
   localparam logic [6:0] DEVICE_ADDRESS_RESET = 7'h56;
   localparam logic [7:0] RETRY_LIMIT_RESET    = 8'd200;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_START  = 4'd1,
      PH_SLAW   = 4'd2,
      PH_SUB    = 4'd3,
      PH_TX     = 4'd4,
      PH_RSTART = 4'd5,
      PH_SLAR   = 4'd6,
      PH_RX     = 4'd7
   } phase_type;

   // One result word
   typedef struct packed {
      logic [2:0] bus_action;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic [1:0] outcome;
      logic [7:0] bytes_done;
   } rsp_type;

endpackage

FILE: rtl/i2c_rtm_core.sv
module i2c_rtm_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [1:0]          cmd,
   input  logic [7:0]          sub_address,
   input  logic [7:0]          byte_count,
   input  logic [3:0]          bus_status,
   input  logic [7:0]          bus_read_byte,
   input  logic [7:0]          next_write_byte,
   input  logic [6:0]          device_address,
   input  logic [7:0]          retry_limit,
   output i2c_rtm_pkg::rsp_type result
);
   import i2c_rtm_pkg::*;

   phase_type  phase_ff, phase_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] held_sub_ff, held_sub_in;
   logic [7:0] bytes_left_ff, bytes_left_in;
   logic [7:0] bytes_moved_ff, bytes_moved_in;
   logic [7:0] retry_count_ff, retry_count_in;

   logic [7:0] sla;
   logic [7:0] left_dec;
   logic [7:0] moved_inc;

   assign sla       = {device_address, 1'b0};
   assign left_dec  = bytes_left_ff - 8'd1;
   assign moved_inc = bytes_moved_ff + 8'd1;

   // Advance the transfer state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         is_read_ff     <= 1'b0;
         held_sub_ff    <= 8'd0;
         bytes_left_ff  <= 8'd0;
         bytes_moved_ff <= 8'd0;
         retry_count_ff <= 8'd0;
      end else if (step) begin
         phase_ff       <= phase_in;
         is_read_ff     <= is_read_in;
         held_sub_ff    <= held_sub_in;
         bytes_left_ff  <= bytes_left_in;
         bytes_moved_ff <= bytes_moved_in;
         retry_count_ff <= retry_count_in;
      end
   end

   // Next phase and bus action
   always_comb begin
      phase_in       = phase_ff;
      is_read_in     = is_read_ff;
      held_sub_in    = held_sub_ff;
      bytes_left_in  = bytes_left_ff;
      bytes_moved_in = bytes_moved_ff;
      retry_count_in = retry_count_ff;
      result         = '0;

      case (cmd)
         CMD_WRITE, CMD_READ: begin
            if (phase_ff == PH_IDLE) begin
               is_read_in     = cmd[0];
               held_sub_in    = sub_address;
               bytes_left_in  = byte_count;
               bytes_moved_in = 8'd0;
               if (retry_limit == 8'd0) begin
                  retry_count_in  = 8'd0;
                  result.done_res = 1'b1;
                  result.outcome  = OC_RETRIES;
               end else begin
                  retry_count_in    = 8'd1;
                  phase_in          = PH_START;
                  result.bus_action = ACT_START;
               end
            end
         end
         CMD_STATUS: begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_START: begin
                  if (bus_status == ST_START || bus_status == ST_RSTART) begin
                     phase_in          = PH_SLAW;
                     result.bus_action = ACT_SEND;
                     result.tx_byte    = sla;
                  end else if (bus_status == ST_ARB_LOST) begin
                     result.bus_action = ACT_START;
                  end else begin
                     phase_in        = PH_IDLE;
                     result.done_res = 1'b1;
                     result.outcome  = OC_START_ERR;
                  end
               end
               PH_SLAW: begin
                  if (bus_status == ST_SLAW_ACK) begin
                     phase_in          = PH_SUB;
                     result.bus_action = ACT_SEND;
                     result.tx_byte    = held_sub_ff;
                  end else if (bus_status == ST_SLAW_NACK) begin
                     if (retry_count_ff >= retry_limit) begin
                        phase_in        = PH_IDLE;
                        result.done_res = 1'b1;
                        result.outcome  = OC_RETRIES;
                     end else begin
                        retry_count_in    = retry_count_ff + 8'd1;
                        phase_in          = PH_START;
                        result.bus_action = ACT_START;
                     end
                  end else if (bus_status == ST_ARB_LOST) begin
                     phase_in          = PH_START;
                     result.bus_action = ACT_START;
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               PH_SUB: begin
                  if (bus_status == ST_TX_ACK) begin
                     if (is_read_ff) begin
                        phase_in          = PH_RSTART;
                        result.bus_action = ACT_START;
                     end else if (bytes_left_ff != 8'd0) begin
                        phase_in          = PH_TX;
                        result.bus_action = ACT_SEND;
                        result.tx_byte    = next_write_byte;
                     end else begin
                        phase_in          = PH_IDLE;
                        result.bus_action = ACT_STOP;
                        result.done_res   = 1'b1;
                        result.bytes_done = bytes_moved_ff;
                     end
                  end else if (bus_status == ST_TX_NACK) begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.bytes_done = bytes_moved_ff;
                  end else if (bus_status == ST_ARB_LOST) begin
                     phase_in          = PH_START;
                     result.bus_action = ACT_START;
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               PH_TX: begin
                  if (bus_status == ST_TX_ACK) begin
                     bytes_moved_in = moved_inc;
                     bytes_left_in  = left_dec;
                     if (left_dec != 8'd0) begin
                        result.bus_action = ACT_SEND;
                        result.tx_byte    = next_write_byte;
                     end else begin
                        phase_in          = PH_IDLE;
                        result.bus_action = ACT_STOP;
                        result.done_res   = 1'b1;
                        result.bytes_done = moved_inc;
                     end
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               PH_RSTART: begin
                  if (bus_status == ST_START || bus_status == ST_RSTART) begin
                     phase_in          = PH_SLAR;
                     result.bus_action = ACT_SEND;
                     result.tx_byte    = sla | 8'd1;
                  end else if (bus_status == ST_ARB_LOST) begin
                     phase_in          = PH_START;
                     result.bus_action = ACT_START;
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               PH_SLAR: begin
                  if (bus_status == ST_SLAR_ACK && bytes_left_ff != 8'd0) begin
                     phase_in          = PH_RX;
                     result.bus_action = (bytes_left_ff > 8'd1) ? ACT_RX_ACK : ACT_RX_NACK;
                  end else if (bus_status == ST_SLAR_ACK || bus_status == ST_SLAR_NACK) begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.bytes_done = bytes_moved_ff;
                  end else if (bus_status == ST_ARB_LOST) begin
                     phase_in          = PH_START;
                     result.bus_action = ACT_START;
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               PH_RX: begin
                  if (bus_status == ST_RX_ACK || bus_status == ST_RX_NACK) begin
                     bytes_moved_in  = moved_inc;
                     bytes_left_in   = left_dec;
                     result.rx_valid = 1'b1;
                     result.rx_byte  = bus_read_byte;
                     if (bus_status == ST_RX_NACK || left_dec == 8'd0) begin
                        phase_in          = PH_IDLE;
                        result.bus_action = ACT_STOP;
                        result.done_res   = 1'b1;
                        result.bytes_done = moved_inc;
                     end else begin
                        result.bus_action = (left_dec > 8'd1) ? ACT_RX_ACK : ACT_RX_NACK;
                     end
                  end else begin
                     phase_in          = PH_IDLE;
                     result.bus_action = ACT_STOP;
                     result.done_res   = 1'b1;
                     result.outcome    = OC_BUS_ERR;
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/i2c_register_transfer_master.sv
// I2C master register transfer sequencer. A start word (write or read, with
// sub-address and byte count) opens a transfer; each later bus status word
// moves it one phase on. Every accepted word yields exactly one result word:
// the next bus action, any received byte, and on the last word of a transfer
// the outcome and byte count. Each word is worked straight into the result
// register, so a new word is taken every cycle unless that register is full
// and stalled. Configuration is written through the always-ready csr port;
// the user must write it only while the block is idle; this is not enforced.
module i2c_register_transfer_master (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [7:0]                          req_sub_address,
   input  logic [7:0]                          req_byte_count,
   input  logic [3:0]                          req_bus_status,
   input  logic [7:0]                          req_bus_read_byte,
   input  logic [7:0]                          req_next_write_byte,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_bus_action,
   output logic [7:0]                          rsp_tx_byte,
   output logic                                rsp_rx_valid,
   output logic [7:0]                          rsp_rx_byte,
   output logic                                rsp_done_res,
   output logic [1:0]                          rsp_outcome,
   output logic [7:0]                          rsp_bytes_done,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [i2c_rtm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2c_rtm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import i2c_rtm_pkg::*;

   logic [6:0] device_address_ff;
   logic [7:0] retry_limit_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff;
   rsp_type    step_result;
   logic       accept;

   assign csr_ready = 1'b1;
   assign req_stall = reset | (rsp_valid_ff & rsp_stall);
   assign accept    = req_valid & ~req_stall;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         device_address_ff <= DEVICE_ADDRESS_RESET;
         retry_limit_ff    <= RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_DEVICE_ADDRESS) begin
            device_address_ff <= csr_wdata[6:0];
         end
         if (csr_index == REG_RETRY_LIMIT) begin
            retry_limit_ff <= csr_wdata[7:0];
         end
      end
   end

   i2c_rtm_core u_core (
      .clock           (clock),
      .reset           (reset),
      .step            (accept),
      .cmd             (req_cmd),
      .sub_address     (req_sub_address),
      .byte_count      (req_byte_count),
      .bus_status      (req_bus_status),
      .bus_read_byte   (req_bus_read_byte),
      .next_write_byte (req_next_write_byte),
      .device_address  (device_address_ff),
      .retry_limit     (retry_limit_ff),
      .result          (step_result)
   );

   // Hold the result word until taken
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bus_action = rsp_data_ff.bus_action;
   assign rsp_tx_byte    = rsp_data_ff.tx_byte;
   assign rsp_rx_valid   = rsp_data_ff.rx_valid;
   assign rsp_rx_byte    = rsp_data_ff.rx_byte;
   assign rsp_done_res   = rsp_data_ff.done_res;
   assign rsp_outcome    = rsp_data_ff.outcome;
   assign rsp_bytes_done = rsp_data_ff.bytes_done;

endmodule

FILE: rtl/i2c_rtm_checker.sv
`include "i2c_register_transfer_master_defines.svh"

module i2c_rtm_props (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [2:0] rsp_bus_action,
   input logic [7:0] rsp_tx_byte,
   input logic       rsp_done_res,
   input logic [1:0] rsp_outcome,
   input logic [7:0] rsp_bytes_done
);
   import i2c_rtm_pkg::*;

   logic        rsp_blocked;
   logic [21:0] rsp_word;
   logic        fields_clean;

   assign rsp_blocked = rsp_valid && rsp_stall;
   assign rsp_word    = {rsp_bus_action, rsp_tx_byte, rsp_done_res, rsp_outcome, rsp_bytes_done};

   // A transmit byte, an outcome and a count only appear where they mean something
   assign fields_clean = (rsp_bus_action == ACT_SEND || rsp_tx_byte == 8'd0)
                         && (rsp_done_res || rsp_outcome == OC_OK)
                         && (rsp_outcome == OC_OK || rsp_bytes_done == 8'd0);

   // A stalled result word holds
   `RTM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_blocked, rsp_valid && $stable(rsp_word))
   // No word is taken while a full result register is stalled
   `RTM_ASSERT_NOW(a_no_overrun, clock, reset, rsp_blocked, req_stall)
   // Every accepted word yields a result word next cycle
   `RTM_ASSERT_NEXT(a_one_result, clock, reset, req_valid && !req_stall, rsp_valid)
   // Result fields are clean
   `RTM_ASSERT_NOW(a_clean_fields, clock, reset, rsp_valid, fields_clean)

endmodule

bind i2c_register_transfer_master i2c_rtm_props u_checker (.*);

FILE: tb/i2c_rtm_checker.sv
module i2c_rtm_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_cmd,
   input  logic [7:0]                          req_sub_address,
   input  logic [7:0]                          req_byte_count,
   input  logic [3:0]                          req_bus_status,
   input  logic [7:0]                          req_bus_read_byte,
   input  logic [7:0]                          req_next_write_byte,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [2:0]                          rsp_bus_action,
   input  logic [7:0]                          rsp_tx_byte,
   input  logic                                rsp_rx_valid,
   input  logic [7:0]                          rsp_rx_byte,
   input  logic                                rsp_done_res,
   input  logic [1:0]                          rsp_outcome,
   input  logic [7:0]                          rsp_bytes_done,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [i2c_rtm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [i2c_rtm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                  mismatches,
   output int                                  words_pending,
   output int                                  words_checked,
   output int                                  transfers_closed,
   output i2c_rtm_pkg::phase_type              xfer_phase
);
   import i2c_rtm_pkg::*;

   // Local copy of the registers and the transfer state
   logic [6:0] dev_addr;
   logic [7:0] retry_max;
   logic       rd_xfer;
   logic [7:0] sub_addr;
   logic [7:0] left;
   logic [7:0] moved;
   logic [7:0] attempts;

   rsp_type bus_words_due[$];

   task automatic flag_mismatch(input string what, input int got, input int want);
      if (mismatches < 100) begin
         $display("word %0d: %s is %0d, want %0d (t=%0t)", words_checked, what, got, want,
                  $realtime);
      end
      mismatches++;
   endtask

   // End the transfer; the byte count is only reported on a clean finish
   function automatic rsp_type close_xfer(input logic [2:0] act, input logic [1:0] oc,
                                         input logic rxv, input logic [7:0] rxb);
      rsp_type r;
      r = '0;
      r.bus_action = act;
      r.rx_valid   = rxv;
      r.rx_byte    = rxv ? rxb : 8'd0;
      r.done_res   = 1'b1;
      r.outcome    = oc;
      r.bytes_done = (oc == OC_OK) ? moved : 8'd0;
      xfer_phase   = PH_IDLE;
      return r;
   endfunction

   // Go back to the opening start condition, keeping the attempt count
   function automatic rsp_type restart_xfer();
      rsp_type r;
      r = '0;
      r.bus_action = ACT_START;
      xfer_phase   = PH_START;
      return r;
   endfunction

   function automatic rsp_type send_byte_word(input phase_type nxt, input logic [7:0] b);
      rsp_type r;
      r = '0;
      r.bus_action = ACT_SEND;
      r.tx_byte    = b;
      xfer_phase   = nxt;
      return r;
   endfunction

   // Ask for the next byte, with a NACK on the last one
   function automatic rsp_type recv_word();
      rsp_type r;
      r = '0;
      r.bus_action = (left > 8'd1) ? ACT_RX_ACK : ACT_RX_NACK;
      xfer_phase   = PH_RX;
      return r;
   endfunction

   // Work out the result word for one request word and advance the state
   function automatic rsp_type next_bus_word(input logic [1:0] cmd, input logic [7:0] sub,
                                             input logic [7:0] cnt, input logic [3:0] st,
                                             input logic [7:0] rxb, input logic [7:0] wb);
      rsp_type    r;
      logic [7:0] sla;
      r   = '0;
      sla = {dev_addr, 1'b0};
      if (cmd == CMD_WRITE || cmd == CMD_READ) begin
         if (xfer_phase != PH_IDLE) return r;
         rd_xfer  = (cmd == CMD_READ);
         sub_addr = sub;
         left     = cnt;
         moved    = 8'd0;
         if (retry_max == 8'd0) begin
            attempts = 8'd0;
            return close_xfer(ACT_NONE, OC_RETRIES, 1'b0, 8'd0);
         end
         attempts = 8'd1;
         return restart_xfer();
      end
      if (cmd != CMD_STATUS || xfer_phase == PH_IDLE) return r;

      case (xfer_phase)
         PH_START: begin
            if (st == ST_START || st == ST_RSTART) r = send_byte_word(PH_SLAW, sla);
            else if (st == ST_ARB_LOST) r = restart_xfer();
            else r = close_xfer(ACT_NONE, OC_START_ERR, 1'b0, 8'd0);
         end
         PH_SLAW: begin
            if (st == ST_SLAW_ACK) begin
               r = send_byte_word(PH_SUB, sub_addr);
            end else if (st == ST_SLAW_NACK) begin
               if (attempts >= retry_max) begin
                  r = close_xfer(ACT_NONE, OC_RETRIES, 1'b0, 8'd0);
               end else begin
                  attempts = attempts + 8'd1;
                  r = restart_xfer();
               end
            end else if (st == ST_ARB_LOST) begin
               r = restart_xfer();
            end else begin
               r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
            end
         end
         PH_SUB: begin
            if (st == ST_TX_ACK) begin
               if (rd_xfer) begin
                  r.bus_action = ACT_START;
                  xfer_phase   = PH_RSTART;
               end else if (left > 8'd0) begin
                  r = send_byte_word(PH_TX, wb);
               end else begin
                  r = close_xfer(ACT_STOP, OC_OK, 1'b0, 8'd0);
               end
            end else if (st == ST_TX_NACK) begin
               r = close_xfer(ACT_STOP, OC_OK, 1'b0, 8'd0);
            end else if (st == ST_ARB_LOST) begin
               r = restart_xfer();
            end else begin
               r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
            end
         end
         PH_TX: begin
            if (st == ST_TX_ACK) begin
               moved = moved + 8'd1;
               left  = left - 8'd1;
               if (left > 8'd0) r = send_byte_word(PH_TX, wb);
               else r = close_xfer(ACT_STOP, OC_OK, 1'b0, 8'd0);
            end else begin
               r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
            end
         end
         PH_RSTART: begin
            if (st == ST_START || st == ST_RSTART) r = send_byte_word(PH_SLAR, sla | 8'd1);
            else if (st == ST_ARB_LOST) r = restart_xfer();
            else r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
         end
         PH_SLAR: begin
            if (st == ST_SLAR_ACK) begin
               if (left > 8'd0) r = recv_word();
               else r = close_xfer(ACT_STOP, OC_OK, 1'b0, 8'd0);
            end else if (st == ST_SLAR_NACK) begin
               r = close_xfer(ACT_STOP, OC_OK, 1'b0, 8'd0);
            end else if (st == ST_ARB_LOST) begin
               r = restart_xfer();
            end else begin
               r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
            end
         end
         PH_RX: begin
            if (st == ST_RX_ACK || st == ST_RX_NACK) begin
               moved = moved + 8'd1;
               left  = left - 8'd1;
               if (st == ST_RX_NACK || left == 8'd0) begin
                  r = close_xfer(ACT_STOP, OC_OK, 1'b1, rxb);
               end else begin
                  r = recv_word();
                  r.rx_valid = 1'b1;
                  r.rx_byte  = rxb;
               end
            end else begin
               r = close_xfer(ACT_STOP, OC_BUS_ERR, 1'b0, 8'd0);
            end
         end
         default: xfer_phase = PH_IDLE;
      endcase
      return r;
   endfunction

   // Track register writes, check result words, queue new predictions
   always @(posedge clock) begin
      rsp_type seen;
      rsp_type due;
      if (reset) begin
         dev_addr   = DEVICE_ADDRESS_RESET;
         retry_max  = RETRY_LIMIT_RESET;
         xfer_phase = PH_IDLE;
         rd_xfer    = 1'b0;
         sub_addr   = 8'd0;
         left       = 8'd0;
         moved      = 8'd0;
         attempts   = 8'd0;
         bus_words_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DEVICE_ADDRESS: dev_addr = csr_wdata[6:0];
               REG_RETRY_LIMIT:    retry_max = csr_wdata[7:0];
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_bus_action, rsp_tx_byte, rsp_rx_valid, rsp_rx_byte,
                    rsp_done_res, rsp_outcome, rsp_bytes_done};
            if (bus_words_due.size() == 0) begin
               flag_mismatch("unexpected word, bus_action", int'(seen.bus_action), 0);
            end else begin
               due = bus_words_due.pop_front();
               if (seen.bus_action !== due.bus_action)
                  flag_mismatch("bus_action", int'(seen.bus_action), int'(due.bus_action));
               if (seen.tx_byte !== due.tx_byte)
                  flag_mismatch("tx_byte", int'(seen.tx_byte), int'(due.tx_byte));
               if (seen.rx_valid !== due.rx_valid)
                  flag_mismatch("rx_valid", int'(seen.rx_valid), int'(due.rx_valid));
               if (seen.rx_byte !== due.rx_byte)
                  flag_mismatch("rx_byte", int'(seen.rx_byte), int'(due.rx_byte));
               if (seen.done_res !== due.done_res)
                  flag_mismatch("done_res", int'(seen.done_res), int'(due.done_res));
               if (seen.outcome !== due.outcome)
                  flag_mismatch("outcome", int'(seen.outcome), int'(due.outcome));
               if (seen.bytes_done !== due.bytes_done)
                  flag_mismatch("bytes_done", int'(seen.bytes_done), int'(due.bytes_done));
               if (due.done_res) transfers_closed++;
               words_checked++;
            end
         end
         if (req_valid && !req_stall) begin
            bus_words_due.push_back(next_bus_word(req_cmd, req_sub_address, req_byte_count,
                                                  req_bus_status, req_bus_read_byte,
                                                  req_next_write_byte));
         end
      end
      words_pending = bus_words_due.size();
   end

endmodule

FILE: tb/tb.sv
module tb;
   import i2c_rtm_pkg::*;

   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam logic [3:0] ST_OTHER  = 4'd11;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_cmd = CMD_STATUS;
   logic [7:0]             req_sub_address = 8'd0;
   logic [7:0]             req_byte_count = 8'd0;
   logic [3:0]             req_bus_status = ST_OTHER;
   logic [7:0]             req_bus_read_byte = 8'd0;
   logic [7:0]             req_next_write_byte = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [2:0]             rsp_bus_action;
   logic [7:0]             rsp_tx_byte;
   logic                   rsp_rx_valid;
   logic [7:0]             rsp_rx_byte;
   logic                   rsp_done_res;
   logic [1:0]             rsp_outcome;
   logic [7:0]             rsp_bytes_done;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = REG_DEVICE_ADDRESS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int        mismatches;
   int        words_pending;
   int        words_checked;
   int        transfers_closed;
   phase_type xfer_phase;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   logic hold_on = 1'b0;
   event long_hold;

   i2c_register_transfer_master dut (.*);

   i2c_rtm_checker checker_i (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Give up on a hung run
   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Hold the result channel off for a long stretch on request
   always @(long_hold) begin
      @(posedge clock);
      hold_on = 1'b1;
      repeat (80) @(posedge clock);
      hold_on = 1'b0;
   end

   always @(negedge clock) rsp_stall <= hold_on || ($urandom_range(99) < stall_pct);

   // Offer one word, idling first at random, and wait for it to be taken
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] sub, input logic [7:0] cnt,
                            input logic [3:0] st, input logic [7:0] rd, input logic [7:0] wr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_sub_address     <= sub;
      req_byte_count      <= cnt;
      req_bus_status      <= st;
      req_bus_read_byte   <= rd;
      req_next_write_byte <= wr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drop valid and wait for every outstanding result word
   task automatic pause_for_results();
      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
   endtask

   // Close any open transfer with a stray status, then drain
   task automatic settle();
      if (xfer_phase != PH_IDLE) send_word(CMD_STATUS, 8'd0, 8'd0, ST_OTHER, 8'd0, 8'd0);
      pause_for_results();
   endtask

   task automatic set_regs(input logic [6:0] addr, input logic [7:0] limit);
      csr_valid <= 1'b1;
      csr_index <= REG_DEVICE_ADDRESS;
      csr_wdata <= {1'b0, addr};
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_index <= REG_RETRY_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly the status a well-behaved bus would report next, with some noise
   task automatic random_word();
      logic [1:0] cmd;
      logic [3:0] st;
      logic [7:0] cnt;
      int         roll;
      cmd  = CMD_STATUS;
      st   = ST_OTHER;
      roll = $urandom_range(99);
      if (roll < 2) cnt = 8'($urandom_range(255, 200));
      else if (roll < 10) cnt = 8'd0;
      else cnt = 8'($urandom_range(6, 1));
      roll = $urandom_range(99);
      if (roll < 8) begin
         cmd = 2'($urandom_range(3));
         st  = 4'($urandom_range(15));
      end else if (xfer_phase == PH_IDLE) begin
         cmd = ($urandom_range(1) == 0) ? CMD_WRITE : CMD_READ;
      end else begin
         roll = $urandom_range(99);
         case (xfer_phase)
            PH_START:  st = (roll < 5) ? ST_ARB_LOST : (roll < 30) ? ST_RSTART : ST_START;
            PH_SLAW:   st = (roll < 5) ? ST_ARB_LOST : (roll < 25) ? ST_SLAW_NACK : ST_SLAW_ACK;
            PH_SUB:    st = (roll < 4) ? ST_ARB_LOST : (roll < 10) ? ST_TX_NACK : ST_TX_ACK;
            PH_TX:     st = (roll < 3) ? ST_TX_NACK : ST_TX_ACK;
            PH_RSTART: st = (roll < 4) ? ST_ARB_LOST : (roll < 30) ? ST_START : ST_RSTART;
            PH_SLAR:   st = (roll < 4) ? ST_ARB_LOST : (roll < 10) ? ST_SLAR_NACK : ST_SLAR_ACK;
            default:   st = (roll < 8) ? ST_RX_NACK : ST_RX_ACK;
         endcase
      end
      send_word(cmd, 8'($urandom), cnt, st, 8'($urandom), 8'($urandom));
   endtask

   // Random words, with either a long receiver hold-off or a full drain halfway
   task automatic run_words(input int n, input bit with_hold);
      for (int i = 0; i < n; i++) begin
         if (i == n / 2) begin
            if (with_hold) -> long_hold;
            else pause_for_results();
         end
         random_word();
      end
   endtask

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Ignored words while idle
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_ACK, 8'd0, 8'd0);
      send_word(CMD_SPARE, 8'hFF, 8'hFF, ST_OTHER, 8'hFF, 8'hFF);
      // One-byte write at the top sub-address
      send_word(CMD_WRITE, 8'hFF, 8'd1, ST_OTHER, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_START, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_SLAW_ACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_ACK, 8'd0, 8'hFF);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_ACK, 8'd0, 8'h00);
      // Two-byte read, last byte taken with NACK
      send_word(CMD_READ, 8'h00, 8'd2, ST_OTHER, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_RSTART, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_SLAW_ACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_ACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_START, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_SLAR_ACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_RX_ACK, 8'hFF, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_RX_ACK, 8'h00, 8'd0);
      // Full-count write: busy start, arbitration loss, address retry, data NACK
      send_word(CMD_WRITE, 8'h5A, 8'hFF, ST_OTHER, 8'd0, 8'd0);
      send_word(CMD_READ, 8'hA5, 8'd3, ST_OTHER, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_ARB_LOST, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_START, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_SLAW_NACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_START, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_SLAW_ACK, 8'd0, 8'd0);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_ACK, 8'd0, 8'h3C);
      send_word(CMD_STATUS, 8'd0, 8'd0, ST_TX_NACK, 8'd0, 8'd0);
      settle();

      // Reset register values, no idling
      run_words(140, 1'b0);
      settle();

      // Top address, single attempt, sender mostly idle
      set_regs(7'h7F, 8'd1);
      send_idle_pct = 80;
      run_words(140, 1'b0);
      settle();

      // Zero address, no attempts allowed, receiver mostly stalled
      set_regs(7'h00, 8'd0);
      send_idle_pct = 0;
      stall_pct     = 80;
      run_words(60, 1'b0);
      settle();

      // Widest retry budget, both sides idling, long hold-off
      set_regs(7'($urandom), 8'd255);
      send_idle_pct = 29;
      stall_pct     = 29;
      run_words(140, 1'b1);
      settle();

      // Two attempts, no idling, long hold-off
      set_regs(7'($urandom), 8'd2);
      send_idle_pct = 0;
      stall_pct     = 0;
      run_words(140, 1'b1);
      settle();

      repeat (8) @(posedge clock);
      $display("checked %0d result words over %0d finished transfers", words_checked,
               transfers_closed);
      $display("five register settings, idle and stall mixes, long hold-offs and drains");
      if (mismatches == 0 && words_pending == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/i2c_rtm_pkg.sv
rtl/i2c_rtm_core.sv
rtl/i2c_register_transfer_master.sv
rtl/i2c_rtm_checker.sv
tb/i2c_rtm_checker.sv
tb/tb.sv
